@@ hdl/agmc_pkg.sv @@
package agmc_pkg;

  localparam int unsigned CHANNELS_DEF   = 6;
  localparam int unsigned SINE_DEPTH_DEF = 256;

  localparam int unsigned GAIN_REGS     = 6;
  localparam int unsigned MODE_SOFT_BIT = 6;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned Y_W           = 21;
  localparam int unsigned POWER_W       = 32;
  localparam int unsigned MUL_A_W       = 33;
  localparam int unsigned MUL_B_W       = 21;
  localparam int unsigned MUL_P_W       = MUL_A_W + MUL_B_W;
  localparam int unsigned RECIP_SHIFT   = 23;

  localparam logic [2:0]  REG_MODE     = 3'd6;
  localparam logic [2:0]  REG_FORGET   = 3'd7;
  localparam logic [15:0] GAIN_RESET   = 16'd4096;
  localparam logic [6:0]  MODE_RESET   = 7'd63;
  localparam logic [15:0] FORGET_RESET = 16'd129;

  localparam logic [15:0] HALF_PI_Q15 = 16'd51472;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_GAIN,
    ST_SQY,
    ST_METER,
    ST_DECAY,
    ST_DSUM,
    ST_CLIP,
    ST_KDIV,
    ST_KWAIT,
    ST_ROM,
    ST_SIGN,
    ST_OUT
  } state_e;

endpackage

@@ hdl/agmc_mul.sv @@
module agmc_mul import agmc_pkg::*; (
  input  logic                       clk_i,
  input  logic signed [MUL_A_W-1:0]  a_i,
  input  logic signed [MUL_B_W-1:0]  b_i,
  output logic signed [MUL_P_W-1:0]  prod_o
);

  logic signed [MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

@@ hdl/agmc_div.sv @@
module agmc_div import agmc_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
  localparam int unsigned KW = $clog2(SINE_TABLE_DEPTH),
  localparam int unsigned RW = 16 + KW
) (
  input  logic [RW-1:0] dividend_i,
  input  logic [KW-1:0] quot_est_i,
  input  logic [RW-1:0] back_i,
  output logic [KW-1:0] quot_o
);

  logic [RW-1:0] rem;
  logic          fix;

  // reciprocal estimate is exact or one low
  assign rem    = dividend_i - back_i;
  assign fix    = rem >= RW'(HALF_PI_Q15);
  assign quot_o = quot_est_i + KW'(fix);

endmodule

@@ hdl/agmc_sine_rom.sv @@
module agmc_sine_rom import agmc_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
  localparam int unsigned KW = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [KW-1:0] addr_i,
  output logic [14:0]   data_o
);

  function automatic logic [14:0] sine_entry(input logic [63:0] k);
    logic [63:0] a, a2, t, s, r;
    a  = (k * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
    a2 = (a * a) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd6;
    s  = (a * t) >> 30;
    r  = (s + 64'd16384) >> 15;
    return (r > 64'd32767) ? 15'h7fff : r[14:0];
  endfunction

  logic [14:0] sine_rom [SINE_TABLE_DEPTH];
  logic [14:0] data_q;

  for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
    assign sine_rom[i] = sine_entry(64'(i));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= sine_rom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

@@ hdl/audio_gain_meter_clipper_core.sv @@
// channel | direction | handshake             | payload
// in      | input     | in_valid_i / in_stall_o   | sample_in_i, channel_i, frame_end_i
// out     | output    | out_valid_o / out_stall_i | sample_out_o, channel_out_o,
//         |           |                           | meter_power_o, max_input_power_o,
//         |           |                           | frame_end_out_o
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// an enabled item passes through the multiplier states, adding the decay steps when
// the meter decays and the divide and sine table steps when a soft clip reads the table
// a disabled item goes straight to the output state; one shared multiplier sets the pace
// the output register holds a result while out_stall_i is high; a new item
// is taken only once the previous result sits in that register
// reset clears both meters and loads the register defaults

module audio_gain_meter_clipper_core import agmc_pkg::*; #(
  parameter int unsigned CHANNELS         = CHANNELS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic [2:0]                 channel_i,
  input  logic                       frame_end_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic [2:0]                 channel_out_o,
  output logic [POWER_W-1:0]         meter_power_o,
  output logic [POWER_W-1:0]         max_input_power_o,
  output logic                       frame_end_out_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [2:0]                 cfg_index_i,
  input  logic [15:0]                cfg_data_i
);

  localparam int unsigned KW  = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned RW  = 16 + KW;
  localparam int unsigned CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [63:0] RECIP =
    (64'(SINE_TABLE_DEPTH) << RECIP_SHIFT) / 64'(HALF_PI_Q15);

  state_e state_q, state_d;

  logic [15:0] gain_q [GAIN_REGS];
  logic [6:0]  mode_q;
  logic [15:0] forget_q;
  logic [POWER_W-1:0] meter_q [CHANNELS];
  logic [POWER_W-1:0] maxp_q  [CHANNELS];

  logic signed [SAMPLE_W-1:0] x_q, res_q, res_d;
  logic [2:0]                 ch_q;
  logic                       fe_q, inr_q;
  logic signed [Y_W-1:0]      y_q, y_d;
  logic [POWER_W-1:0]         po_q, po_d;
  logic [48:0]                acc_q, acc_d;
  logic [RW-1:0]              n_q, n_d;
  logic [KW-1:0]              kest_q, kest_d;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic [2:0]                 out_ch_q;
  logic [POWER_W-1:0]         out_meter_q, out_maxp_q;
  logic                       out_fe_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  logic [KW-1:0] k;
  logic          rom_en;
  logic [14:0]   rom_data;

  logic               in_acc, en_in, inr_in, out_load;
  logic [CHW-1:0]     chi;
  logic [POWER_W-1:0] meter_cur, maxp_cur, pin, po_sat;
  logic               max_we, meter_we;
  logic [POWER_W-1:0] meter_wd;
  logic [49:0]        dsum;
  logic signed [Y_W-1:0] mag21;
  logic [15:0]        mag;

  agmc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  agmc_div #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_div (
    .dividend_i (n_q),
    .quot_est_i (kest_q),
    .back_i     (prod[RW-1:0]),
    .quot_o     (k)
  );

  agmc_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom (
    .clk_i  (clk_i),
    .en_i   (rom_en),
    .addr_i (k),
    .data_o (rom_data)
  );

  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign inr_in = (channel_i < 3'(GAIN_REGS)) && (32'(channel_i) < CHANNELS);
  assign en_in  = inr_in && mode_q[channel_i];

  assign chi       = ch_q[CHW-1:0];
  assign meter_cur = meter_q[chi];
  assign maxp_cur  = maxp_q[chi];
  assign pin       = prod[37:6];
  assign po_sat    = (|prod[MUL_P_W-1:38]) ? '1 : prod[37:6];
  assign dsum      = {1'b0, acc_q} + {1'b0, prod[48:0]};
  assign mag21     = y_q[Y_W-1] ? -y_q : y_q;
  assign mag       = mag21[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    rom_en    = 1'b0;
    max_we    = 1'b0;
    meter_we  = 1'b0;
    meter_wd  = po_sat;
    out_load  = 1'b0;
    y_d       = y_q;
    po_d      = po_q;
    acc_d     = acc_q;
    res_d     = res_q;
    n_d       = n_q;
    kest_d    = kest_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d   = sample_in_i;
          state_d = en_in ? ST_SQX : ST_OUT;
        end
      end
      ST_SQX: begin
        mul_a   = MUL_A_W'(x_q);
        mul_b   = MUL_B_W'(x_q);
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        max_we  = pin > maxp_cur;
        mul_a   = MUL_A_W'(x_q);
        mul_b   = $signed({5'b0, gain_q[ch_q]});
        state_d = ST_SQY;
      end
      ST_SQY: begin
        y_d     = $signed(prod[32:12]);
        mul_a   = MUL_A_W'(y_d);
        mul_b   = y_d;
        state_d = ST_METER;
      end
      ST_METER: begin
        po_d = po_sat;
        if (po_sat > meter_cur) begin
          meter_we = 1'b1;
          state_d  = ST_CLIP;
        end else begin
          mul_a   = $signed({1'b0, meter_cur});
          mul_b   = $signed({4'b0, 17'h10000 - {1'b0, forget_q}});
          state_d = ST_DECAY;
        end
      end
      ST_DECAY: begin
        acc_d   = prod[48:0];
        mul_a   = $signed({1'b0, po_q});
        mul_b   = $signed({5'b0, forget_q});
        state_d = ST_DSUM;
      end
      ST_DSUM: begin
        meter_we = 1'b1;
        meter_wd = dsum[47:16];
        state_d  = ST_CLIP;
      end
      ST_CLIP: begin
        if (mode_q[MODE_SOFT_BIT]) begin
          if (y_q >= $signed(Y_W'(HALF_PI_Q15))) begin
            res_d   = 16'sh7fff;
            state_d = ST_OUT;
          end else if (y_q <= -$signed(Y_W'(HALF_PI_Q15))) begin
            res_d   = -16'sh8000;
            state_d = ST_OUT;
          end else begin
            mul_a   = $signed({17'b0, mag});
            mul_b   = MUL_B_W'(SINE_TABLE_DEPTH);
            state_d = ST_KDIV;
          end
        end else begin
          if (y_q > $signed(Y_W'(32767))) begin
            res_d = 16'sh7fff;
          end else if (y_q < -$signed(Y_W'(32768))) begin
            res_d = -16'sh8000;
          end else begin
            res_d = y_q[15:0];
          end
          state_d = ST_OUT;
        end
      end
      ST_KDIV: begin
        n_d     = prod[RW-1:0];
        mul_a   = $signed({17'b0, mag});
        mul_b   = MUL_B_W'(RECIP);
        state_d = ST_KWAIT;
      end
      ST_KWAIT: begin
        kest_d  = prod[RECIP_SHIFT +: KW];
        mul_a   = MUL_A_W'(kest_d);
        mul_b   = MUL_B_W'(HALF_PI_Q15);
        state_d = ST_ROM;
      end
      ST_ROM: begin
        rom_en  = 1'b1;
        state_d = ST_SIGN;
      end
      ST_SIGN: begin
        res_d   = y_q[Y_W-1] ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q   <= sample_in_i;
      ch_q  <= channel_i;
      fe_q  <= frame_end_i;
      inr_q <= inr_in;
    end
    y_q    <= y_d;
    po_q   <= po_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
    n_q    <= n_d;
    kest_q <= kest_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GAIN_REGS; i++) begin
        gain_q[i] <= GAIN_RESET;
      end
      mode_q   <= MODE_RESET;
      forget_q <= FORGET_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i < 3'(GAIN_REGS)) begin
        gain_q[cfg_index_i] <= cfg_data_i;
      end else if (cfg_index_i == REG_MODE) begin
        mode_q <= cfg_data_i[6:0];
      end else if (cfg_index_i == REG_FORGET) begin
        forget_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        meter_q[i] <= '0;
        maxp_q[i]  <= '0;
      end
    end else begin
      if (meter_we) begin
        meter_q[chi] <= meter_wd;
      end
      if (max_we) begin
        maxp_q[chi] <= pin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= res_q;
      out_ch_q     <= ch_q;
      out_meter_q  <= inr_q ? meter_cur : '0;
      out_maxp_q   <= inr_q ? maxp_cur : '0;
      out_fe_q     <= fe_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = out_sample_q;
  assign channel_out_o     = out_ch_q;
  assign meter_power_o     = out_meter_q;
  assign max_input_power_o = out_maxp_q;
  assign frame_end_out_o   = out_fe_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("item accepted but block not busy");

  a_decay_no_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DSUM) |-> (dsum[47:16] <= meter_cur))
    else $error("meter decay raised the meter");

  a_max_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GAIN) |=> (maxp_q[chi] >= $past(maxp_cur)))
    else $error("max power fell");

  a_index_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROM) |-> (32'(k) < SINE_TABLE_DEPTH))
    else $error("sine index beyond table");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output overwritten while stalled");
`endif

endmodule

@@ verif/audio_gain_meter_clipper_core_tb.sv @@
`timescale 1ns / 100ps

module audio_gain_meter_clipper_core_tb;
  import agmc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 40;

  typedef struct {
    logic signed [15:0] smp;
    logic [2:0]         ch;
    logic               fe;
  } sample_item_t;

  typedef struct {
    logic signed [15:0] smp;
    logic [2:0]         ch;
    logic [31:0]        meter;
    logic [31:0]        maxp;
    logic               fe;
  } gained_item_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] sample_in_i = '0;
  logic [2:0]         channel_i = '0;
  logic               frame_end_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] sample_out_o;
  logic [2:0]         channel_out_o;
  logic [31:0]        meter_power_o;
  logic [31:0]        max_input_power_o;
  logic               frame_end_out_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;

  audio_gain_meter_clipper_core u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sample_item_t pending_q[$];
  gained_item_t expected_q[$];

  logic [15:0] gain_q[GAIN_REGS];
  logic [6:0]  mode_q;
  logic [15:0] forget_q;
  logic [31:0] meter_st[CHANNELS_DEF];
  logic [31:0] maxp_st[CHANNELS_DEF];

  int  errors = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;
  bit  in_took = 1'b0;
  bit  out_took = 1'b0;
  int  in_gap = 0;
  int  out_wait = 0;

  function automatic logic [31:0] power_of(longint v);
    longint unsigned m;
    longint unsigned p;
    m = (v < 0) ? -v : v;
    p = (m * m) >> 6;
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  function automatic logic [15:0] sine_q15(longint unsigned k);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned r;
    a  = (k * HALF_PI_Q30) / SINE_DEPTH_DEF;
    a2 = (a * a) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((a2 * t) >> 30) / 110;
    t  = ONE_Q30 - ((a2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((a2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((a2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((a2 * t) >> 30) / 6;
    s  = (a * t) >> 30;
    r  = (s + (64'd1 << 14)) >> 15;
    return (r > 32767) ? 16'd32767 : r[15:0];
  endfunction

  function automatic gained_item_t predict_gain_stage(sample_item_t it);
    gained_item_t    r;
    longint          x;
    longint          y;
    longint unsigned mag;
    longint unsigned k;
    longint unsigned acc;
    logic [31:0]     pin;
    logic [31:0]     po;
    logic [15:0]     s;
    r.smp   = it.smp;
    r.ch    = it.ch;
    r.fe    = it.fe;
    r.meter = '0;
    r.maxp  = '0;
    x = longint'(it.smp);
    if (it.ch < CHANNELS_DEF) begin
      if (mode_q[it.ch]) begin
        pin = power_of(x);
        if (pin > maxp_st[it.ch]) maxp_st[it.ch] = pin;
        y = (x * longint'(gain_q[it.ch])) >>> 12;
        po = power_of(y);
        if (po > meter_st[it.ch]) begin
          meter_st[it.ch] = po;
        end else begin
          acc = longint'(meter_st[it.ch]) * (65536 - longint'(forget_q))
              + longint'(po) * longint'(forget_q);
          meter_st[it.ch] = acc[47:16];
        end
        if (mode_q[MODE_SOFT_BIT]) begin
          if (y >= longint'(HALF_PI_Q15)) begin
            r.smp = 16'sh7FFF;
          end else if (y <= -longint'(HALF_PI_Q15)) begin
            r.smp = 16'sh8000;
          end else begin
            mag = (y < 0) ? -y : y;
            k = (mag * SINE_DEPTH_DEF) / longint'(HALF_PI_Q15);
            s = sine_q15(k);
            r.smp = (y < 0) ? -s : s;
          end
        end else begin
          r.smp = (y > 32767) ? 16'sh7FFF : ((y < -32768) ? 16'sh8000 : y[15:0]);
        end
      end
      r.meter = meter_st[it.ch];
      r.maxp  = maxp_st[it.ch];
    end
    return r;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid_i && !in_took)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          sample_item_t it;
          it = pending_q.pop_front();
          sample_in_i <= it.smp;
          channel_i   <= it.ch;
          frame_end_i <= it.fe;
          in_valid_i  <= 1'b1;
          in_gap      <= no_idle ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (out_took) begin
        out_wait = no_idle ? 0 : $urandom_range(0, 3);
      end else if (out_wait > 0 && out_valid_o) begin
        out_wait = out_wait - 1;
      end
      out_stall_i <= (out_wait > 0);
    end
  end

  always @(posedge clk_i) begin
    gained_item_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    in_took  <= in_valid_i && !in_stall_o;
    out_took <= out_valid_o && !out_stall_i;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_q.push_back(predict_gain_stage('{sample_in_i, channel_i, frame_end_i}));
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected item: sample_out %0d channel %0d", sample_out_o, channel_out_o);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (sample_out_o !== want.smp) begin
          $error("sample_out exp %0d got %0d", want.smp, sample_out_o);
          errors++;
        end
        if (channel_out_o !== want.ch) begin
          $error("channel_out exp %0d got %0d", want.ch, channel_out_o);
          errors++;
        end
        if (meter_power_o !== want.meter) begin
          $error("meter_power exp %h got %h", want.meter, meter_power_o);
          errors++;
        end
        if (max_input_power_o !== want.maxp) begin
          $error("max_input_power exp %h got %h", want.maxp, max_input_power_o);
          errors++;
        end
        if (frame_end_out_o !== want.fe) begin
          $error("frame_end_out exp %0d got %0d", want.fe, frame_end_out_o);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < GAIN_REGS) gain_q[idx] = data;
    else if (idx == REG_MODE) mode_q = data[6:0];
    else if (idx == REG_FORGET) forget_q = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic push_item(input logic [15:0] smp, input logic [2:0] ch, input logic fe);
    pending_q.push_back('{smp, ch, fe});
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($signed($urandom_range(0, 128)) - 64);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom());
      default: return 16'($urandom_range(0, 16384));
    endcase
  endfunction

  task automatic random_items(input int n);
    logic [2:0] ch;
    for (int i = 0; i < n; i++) begin
      ch = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      push_item(pick_sample(), ch, ($urandom_range(0, 7) == 0));
    end
  endtask

  initial begin
    logic [6:0]  mode_v;
    logic [15:0] forget_v;
    for (int c = 0; c < GAIN_REGS; c++) gain_q[c] = GAIN_RESET;
    mode_q   = MODE_RESET;
    forget_q = FORGET_RESET;
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      meter_st[c] = '0;
      maxp_st[c]  = '0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults, hard clip
    push_item(16'h7FFF, 3'd0, 1'b0);
    push_item(16'h8000, 3'd0, 1'b1);
    push_item(16'h0000, 3'd1, 1'b0);
    push_item(16'h0001, 3'd2, 1'b0);
    push_item(16'hFFFF, 3'd3, 1'b1);
    push_item(16'h4000, 3'd4, 1'b0);
    push_item(16'h8000, 3'd5, 1'b0);
    push_item(16'h1234, 3'd6, 1'b0);
    push_item(16'h8000, 3'd7, 1'b1);
    wait_drain();

    // soft clip, extreme gains, one channel disabled
    write_reg(3'd0, 16'hFFFF);
    write_reg(3'd1, 16'd0);
    write_reg(3'd2, 16'd2048);
    write_reg(3'd3, 16'd5000);
    write_reg(3'd4, 16'hFFFF);
    write_reg(3'd5, 16'd4096);
    write_reg(REG_MODE, 7'h5F);
    write_reg(REG_FORGET, 16'hFFFF);
    push_item(16'h7FFF, 3'd0, 1'b0);
    push_item(16'h8000, 3'd0, 1'b0);
    push_item(16'h0100, 3'd0, 1'b0);
    push_item(16'h7FFF, 3'd1, 1'b0);
    push_item(16'h0000, 3'd1, 1'b1);
    push_item(16'h7FFF, 3'd2, 1'b0);
    push_item(16'h8001, 3'd3, 1'b0);
    push_item(16'h6000, 3'd3, 1'b0);
    push_item(16'h8000, 3'd4, 1'b0);
    push_item(16'h1234, 3'd5, 1'b0);
    push_item(16'hC000, 3'd5, 1'b1);
    push_item(16'h0001, 3'd6, 1'b0);
    wait_drain();

    for (int ph = 0; ph < 8; ph++) begin
      for (int c = 0; c < GAIN_REGS; c++) write_reg(3'(c), pick_gain());
      case (ph)
        0:       mode_v = 7'h00;
        1:       mode_v = 7'h7F;
        2:       mode_v = 7'h3F;
        default: mode_v = 7'($urandom());
      endcase
      case (ph)
        1:       forget_v = 16'd0;
        2:       forget_v = 16'hFFFF;
        default: forget_v = 16'($urandom());
      endcase
      write_reg(REG_MODE, mode_v);
      write_reg(REG_FORGET, forget_v);
      no_idle = (ph == 3);
      if (ph == 4) begin
        random_items(45);
        wait_drain();
        random_items(45);
      end else begin
        random_items(90);
      end
      wait_drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
